@@ rtl/dtp_pkg.sv @@
// Shared types and constants for the deadline task picker.
// Used by the channel interfaces, the top level and the checker.
`timescale 1ns / 1ps

package dtp_pkg;

	// Table size and derived index width.
	localparam int SLOTS  = 8;
	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	// Fixed field widths of the channels.
	localparam int ID_W       = 16;
	localparam int TIME_W     = 32;
	localparam int PERIOD_W   = 31;
	localparam int KIND_W     = 2;
	localparam int SLOT_OUT_W = 3;

	localparam logic [ID_W-1:0] ID_MAX = '1;

	typedef enum logic [KIND_W-1:0] {
		KIND_IDLE     = 2'd0,
		KIND_TIMED    = 2'd1,
		KIND_PERIODIC = 2'd2,
		KIND_STRICT   = 2'd3
	} kind_t;

	typedef enum logic {
		OP_CREATE = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT
	} state_t;

endpackage

@@ rtl/dtp_item_if.sv @@
// Input channel of the deadline task picker: valid/ready plus one command item.
// Depends on dtp_pkg for the field widths.
`timescale 1ns / 1ps

interface dtp_item_if;
	import dtp_pkg::*;

	logic                valid;
	logic                ready;
	logic                op;
	logic [TIME_W-1:0]   now;
	logic [KIND_W-1:0]   kind;
	logic [PERIOD_W-1:0] period;

	modport source (output valid, output op, output now, output kind, output period,
		input ready);
	modport sink (input valid, input op, input now, input kind, input period,
		output ready);

endinterface

@@ rtl/dtp_res_if.sv @@
// Output channel of the deadline task picker: valid/ready plus one result item.
// Depends on dtp_pkg for the field widths.
`timescale 1ns / 1ps

interface dtp_res_if;
	import dtp_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [ID_W-1:0]       task_id;
	logic [SLOT_OUT_W-1:0] slot;
	logic                  valid_res;

	modport source (output valid, output task_id, output slot, output valid_res,
		input ready);
	modport sink (input valid, input task_id, input slot, input valid_res,
		output ready);

endinterface

@@ rtl/deadline_task_picker.sv @@
// Top level of the deadline task picker: slot table, scan sequencer and result register.
// Depends on dtp_pkg, dtp_item_if and dtp_res_if.
`timescale 1ns / 1ps

// Usage:
// The item channel carries one command per transfer: op selects create or tick, now is
// the current millisecond time, kind and period describe a new task on create.
// The res channel returns exactly one result per command: the task id, the slot it was
// stored into or picked from, and valid_res (stored on create, task picked on tick).
// Every command scans the whole slot table, one entry read per cycle through a single
// read port, and then commits at most one write. The result is registered at commit,
// after the scan and drain states; a new command is taken only once the sequencer has
// committed and is back in idle.
// item.ready is high only while the sequencer is idle.
// Reset frees all slots at once; slot contents are written when a slot is filled.
// A finished result waits in the output register. The next command is accepted and
// scanned while it waits; its commit holds until the waiting result is transferred.
module deadline_task_picker (
	input  logic     clk,
	input  logic     arst_n,
	dtp_item_if.sink item,
	dtp_res_if.source res
);
	import dtp_pkg::*;

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

	// Sequencer and control state.
	state_t            state_q, state_d;
	logic [SLOT_W-1:0] cnt_q;
	logic [SLOTS-1:0]  live_q;
	logic              item_ready, accept, scan_en, commit_en;

	// Captured command.
	logic                op_q;
	logic [TIME_W-1:0]   now_q;
	logic [KIND_W-1:0]   kind_q;
	logic [PERIOD_W-1:0] period_q;

	// Slot table memories.
	logic [ID_W-1:0]     mem_id     [SLOTS];
	kind_t               mem_kind   [SLOTS];
	logic [TIME_W-1:0]   mem_start  [SLOTS];
	logic [PERIOD_W-1:0] mem_period [SLOTS];

	// Scan pipeline.
	logic                vld_s1, vld_s2;
	logic [SLOT_W-1:0]   idx_s1, idx_s2;
	logic                live_s1, live_s2;
	logic [ID_W-1:0]     id_s1, id_s2;
	kind_t               kind_s1, kind_s2;
	logic [TIME_W-1:0]   start_s1;
	logic [PERIOD_W-1:0] period_s1;
	logic [TIME_W-1:0]   due_s2;

	// Running results of the scan.
	logic [TIME_W-1:0] late_best_q, idle_best_q;
	logic [SLOT_W-1:0] late_idx_q, idle_idx_q, free_idx_q;
	logic [ID_W-1:0]   late_id_q, idle_id_q, max_id_q;
	kind_t             late_kind_q;
	logic [TIME_W-1:0] late_next_q;
	logic              any_live_q, free_found_q;

	// Output register.
	logic                  res_vld_q;
	logic [ID_W-1:0]       res_id_q;
	logic [SLOT_OUT_W-1:0] res_slot_q;
	logic                  res_ok_q;

	// Shared arithmetic and evaluation signals.
	logic [TIME_W-1:0] due_sum;
	logic [TIME_W:0]   diff;
	logic [TIME_W-1:0] lag;
	logic              late_hit, idle_hit, id_hit, free_hit;

	// Commit decision signals.
	logic              late_any, idle_any;
	logic [ID_W-1:0]   new_id;
	logic [SLOT_W-1:0] wr_addr;
	logic              wr_all, wr_start, clr_live;
	logic [TIME_W-1:0] start_wdata;
	logic [ID_W-1:0]   r_id;
	logic [SLOT_W-1:0] r_slot;
	logic              r_ok;

	// Next state and sequencer outputs.
	always_comb begin
		state_d    = state_q;
		item_ready = 1'b0;
		scan_en    = 1'b0;
		commit_en  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item.valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				scan_en = 1'b1;
				if (cnt_q == LAST_SLOT) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!vld_s1 && !vld_s2) begin
					state_d = ST_COMMIT;
				end
			end
			ST_COMMIT: begin
				if (!res_vld_q || res.ready) begin
					commit_en = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign item.ready = item_ready;
	assign accept     = item.valid && item_ready;

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			live_q    <= '0;
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= scan_en;
			vld_s2  <= vld_s1;
			if (accept) begin
				cnt_q <= '0;
			end else if (scan_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (commit_en && wr_all) begin
				live_q[wr_addr] <= 1'b1;
			end else if (commit_en && clr_live) begin
				live_q[wr_addr] <= 1'b0;
			end
			if (commit_en) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	// Slot table: one write port used at commit, one registered read port for the scan.
	always_ff @(posedge clk) begin
		if (commit_en && (wr_all || wr_start)) begin
			mem_start[wr_addr] <= start_wdata;
		end
		if (commit_en && wr_all) begin
			mem_id[wr_addr]     <= new_id;
			mem_kind[wr_addr]   <= kind_t'(kind_q);
			mem_period[wr_addr] <= period_q;
		end
		if (scan_en) begin
			id_s1     <= mem_id[cnt_q];
			kind_s1   <= mem_kind[cnt_q];
			start_s1  <= mem_start[cnt_q];
			period_s1 <= mem_period[cnt_q];
			idx_s1    <= cnt_q;
			live_s1   <= live_q[cnt_q];
		end
	end

	// First stage of the shared unit: due time, or plain start for an idle task.
	assign due_sum = start_s1 + ((kind_s1 == KIND_IDLE) ? '0 : TIME_W'(period_s1));

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			due_s2  <= due_sum;
			idx_s2  <= idx_s1;
			live_s2 <= live_s1;
			id_s2   <= id_s1;
			kind_s2 <= kind_s1;
		end
	end

	// Second stage: lateness or wait time, with the borrow telling whether it is overdue.
	assign diff     = {1'b0, now_q} - {1'b0, due_s2};
	assign lag      = diff[TIME_W-1:0];
	assign late_hit = vld_s2 && live_s2 && (kind_s2 != KIND_IDLE) && !diff[TIME_W]
		&& (lag > late_best_q);
	assign idle_hit = vld_s2 && live_s2 && (kind_s2 == KIND_IDLE) && (lag > idle_best_q);
	assign id_hit   = vld_s2 && live_s2 && (!any_live_q || (id_s2 > max_id_q));
	assign free_hit = vld_s2 && !live_s2 && !free_found_q;

	// Command capture and running best candidates.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= item.op;
			now_q        <= item.now;
			kind_q       <= item.kind;
			period_q     <= item.period;
			late_best_q  <= '0;
			idle_best_q  <= '0;
			any_live_q   <= 1'b0;
			max_id_q     <= '0;
			free_found_q <= 1'b0;
		end else begin
			if (late_hit) begin
				late_best_q <= lag;
				late_idx_q  <= idx_s2;
				late_id_q   <= id_s2;
				late_kind_q <= kind_s2;
				late_next_q <= (kind_s2 == KIND_STRICT) ? due_s2 : now_q;
			end
			if (idle_hit) begin
				idle_best_q <= lag;
				idle_idx_q  <= idx_s2;
				idle_id_q   <= id_s2;
			end
			if (id_hit) begin
				max_id_q   <= id_s2;
				any_live_q <= 1'b1;
			end
			if (free_hit) begin
				free_found_q <= 1'b1;
				free_idx_q   <= idx_s2;
			end
		end
	end

	// Commit decision: what to store and what to report.
	assign late_any = (late_best_q != '0);
	assign idle_any = (idle_best_q != '0);
	assign new_id   = !any_live_q ? '0 : ((max_id_q == ID_MAX) ? ID_MAX : max_id_q + 1'b1);

	always_comb begin
		wr_addr     = '0;
		wr_all      = 1'b0;
		wr_start    = 1'b0;
		clr_live    = 1'b0;
		start_wdata = now_q;
		r_id        = '0;
		r_slot      = '0;
		r_ok        = 1'b0;
		if (op_t'(op_q) == OP_CREATE) begin
			r_id    = new_id;
			wr_addr = free_idx_q;
			if (free_found_q) begin
				wr_all = 1'b1;
				r_slot = free_idx_q;
				r_ok   = 1'b1;
			end
		end else if (late_any) begin
			r_id    = late_id_q;
			r_slot  = late_idx_q;
			r_ok    = 1'b1;
			wr_addr = late_idx_q;
			if (late_kind_q == KIND_TIMED) begin
				clr_live = 1'b1;
			end else begin
				wr_start    = 1'b1;
				start_wdata = late_next_q;
			end
		end else if (idle_any) begin
			r_id     = idle_id_q;
			r_slot   = idle_idx_q;
			r_ok     = 1'b1;
			wr_addr  = idle_idx_q;
			wr_start = 1'b1;
		end
	end

	// Result payload register.
	always_ff @(posedge clk) begin
		if (commit_en) begin
			res_id_q   <= r_id;
			res_slot_q <= SLOT_OUT_W'(r_slot);
			res_ok_q   <= r_ok;
		end
	end

	assign res.valid     = res_vld_q;
	assign res.task_id   = res_id_q;
	assign res.slot      = res_slot_q;
	assign res.valid_res = res_ok_q;

endmodule

@@ rtl/dtp_checker.sv @@
// Port-level assertions for the deadline task picker and the bind that attaches them.
// Depends on dtp_pkg and on the port names of deadline_task_picker.
`timescale 1ns / 1ps

module dtp_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           item_valid,
	input logic                           item_ready,
	input logic                           res_valid,
	input logic                           res_ready,
	input logic [dtp_pkg::ID_W-1:0]       res_task_id,
	input logic [dtp_pkg::SLOT_OUT_W-1:0] res_slot,
	input logic                           res_valid_res
);
	import dtp_pkg::*;

	// A stalled result holds its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_task_id)
		&& $stable(res_slot) && $stable(res_valid_res))
		else $error("result changed while stalled");

	// The block goes busy right after taking a command.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("ready stayed high after an input transfer");

	// A new result only comes out of a busy sequencer.
	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(!item_ready))
		else $error("result appeared while idle");

	// A result that stored or picked nothing reports slot zero.
	a_none_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_valid_res |-> res_slot == '0)
		else $error("empty result with nonzero slot");

endmodule

bind deadline_task_picker dtp_checker u_dtp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.item_valid    (item.valid),
	.item_ready    (item.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.res_task_id   (res.task_id),
	.res_slot      (res.slot),
	.res_valid_res (res.valid_res)
);

@@ sim/deadline_task_picker_checker.sv @@
// Scoreboard for the deadline task picker: mirrors the slot table, predicts each result
// from the accepted commands and compares it with every result transfer.
// Depends on dtp_pkg, dtp_item_if and dtp_res_if.
`timescale 1ns / 1ps

module deadline_task_picker_checker (
	input  logic clk,
	input  logic arst_n,
	dtp_item_if  item,
	dtp_res_if   res,
	output int   fail_count,
	output int   outstanding
);
	import dtp_pkg::*;

	typedef struct packed {
		logic [ID_W-1:0]       task_id;
		logic [SLOT_OUT_W-1:0] slot;
		logic                  valid_res;
	} outcome_t;

	// Mirror of the slot table.
	logic                live     [SLOTS];
	logic [ID_W-1:0]     task_ids [SLOTS];
	kind_t               kinds    [SLOTS];
	logic [TIME_W-1:0]   starts   [SLOTS];
	logic [PERIOD_W-1:0] periods  [SLOTS];

	outcome_t expected_outcomes [$];
	outcome_t want;
	int       mismatches = 0;
	int       waiting    = 0;

	assign fail_count  = mismatches;
	assign outstanding = waiting;

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] wanted);
		$display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, wanted);
		mismatches++;
	endtask

	// Create: the id is one above the largest live id and saturates; the lowest free
	// slot takes the task, and a full table stores nothing.
	function automatic outcome_t create_task(input logic [TIME_W-1:0] now, input kind_t kind,
		input logic [PERIOD_W-1:0] period);
		logic [ID_W:0] next;
		outcome_t      out;
		next = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (live[i] && ({1'b0, task_ids[i]} + 1'b1) > next) begin
				next = {1'b0, task_ids[i]} + 1'b1;
			end
		end
		out = '0;
		out.task_id = (next > {1'b0, ID_MAX}) ? ID_MAX : next[ID_W-1:0];
		for (int i = 0; i < SLOTS; i++) begin
			if (!live[i] && !out.valid_res) begin
				live[i]     = 1'b1;
				task_ids[i] = out.task_id;
				kinds[i]    = kind;
				starts[i]   = now;
				periods[i]  = period;
				out.slot      = SLOT_OUT_W'(i);
				out.valid_res = 1'b1;
			end
		end
		return out;
	endfunction

	// Tick: the most overdue time-based task wins, else the longest-waiting idle task;
	// ties keep the lower slot. The chosen task is then restarted, advanced or freed.
	function automatic outcome_t pick_task(input logic [TIME_W-1:0] now);
		int                late_pick;
		int                idle_pick;
		int                pick;
		logic [TIME_W-1:0] most_late;
		logic [TIME_W-1:0] most_idle;
		logic [TIME_W-1:0] due;
		logic [TIME_W-1:0] waited;
		outcome_t          out;
		late_pick = -1;
		idle_pick = -1;
		most_late = '0;
		most_idle = '0;
		out = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (live[i]) begin
				if (kinds[i] == KIND_IDLE) begin
					waited = now - starts[i];
					if (waited > most_idle) begin
						most_idle = waited;
						idle_pick = i;
					end
				end else begin
					due = starts[i] + TIME_W'(periods[i]);
					if (now > due && (now - due) > most_late) begin
						most_late = now - due;
						late_pick = i;
					end
				end
			end
		end
		pick = (late_pick >= 0) ? late_pick : idle_pick;
		if (pick >= 0) begin
			out.task_id   = task_ids[pick];
			out.slot      = SLOT_OUT_W'(pick);
			out.valid_res = 1'b1;
			case (kinds[pick])
				KIND_TIMED: begin
					live[pick] = 1'b0;
				end
				KIND_STRICT: begin
					starts[pick] = starts[pick] + TIME_W'(periods[pick]);
				end
				default: begin
					starts[pick] = now;
				end
			endcase
		end
		return out;
	endfunction

	// Results are checked before the command of the same edge is predicted.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				live[i] = 1'b0;
			end
			expected_outcomes.delete();
			waiting <= 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_outcomes.size() == 0) begin
					report_mismatch("result transfer with nothing expected",
						{res.task_id, 12'd0, res.slot, res.valid_res}, 32'd0);
				end else begin
					want = expected_outcomes.pop_front();
					if (res.task_id !== want.task_id) begin
						report_mismatch("task_id", 32'(res.task_id), 32'(want.task_id));
					end
					if (res.slot !== want.slot) begin
						report_mismatch("slot", 32'(res.slot), 32'(want.slot));
					end
					if (res.valid_res !== want.valid_res) begin
						report_mismatch("valid_res", 32'(res.valid_res), 32'(want.valid_res));
					end
				end
			end
			if (item.valid && item.ready) begin
				if (op_t'(item.op) == OP_CREATE) begin
					expected_outcomes.push_back(create_task(item.now, kind_t'(item.kind),
						item.period));
				end else begin
					expected_outcomes.push_back(pick_task(item.now));
				end
			end
			waiting <= expected_outcomes.size();
		end
	end

endmodule

@@ sim/deadline_task_picker_tb.sv @@
// Testbench top for the deadline task picker: clock, reset, command stimulus with random
// gaps and result back-pressure, and the final verdict.
// Depends on dtp_pkg, the channel interfaces, the block and deadline_task_picker_checker.
`timescale 1ns / 1ps

module deadline_task_picker_tb;
	import dtp_pkg::*;

	logic              clk = 1'b0;
	logic              arst_n;
	int unsigned       cyc = 0;
	int                fail_count;
	int                outstanding;
	logic [TIME_W-1:0] base_ms;
	int                lasting;

	dtp_item_if item_ch ();
	dtp_res_if  res_ch ();

	deadline_task_picker u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.res    (res_ch)
	);

	deadline_task_picker_checker u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.res         (res_ch),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// Window in which neither side idles.
	function automatic logic steady_window();
		return (cyc >= 6000) && (cyc < 9000);
	endfunction

	// Offer one command after a random number of idle cycles and hold it until the transfer.
	task automatic send_item(input op_t op, input logic [TIME_W-1:0] now, input kind_t kind,
		input logic [PERIOD_W-1:0] period);
		while (!steady_window() && $urandom_range(99) < 25) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid  <= 1'b1;
		item_ch.op     <= op;
		item_ch.now    <= now;
		item_ch.kind   <= kind;
		item_ch.period <= period;
		@(posedge clk);
		while (!item_ch.ready) begin
			@(posedge clk);
		end
	endtask

	// Mostly a steadily advancing clock with short timed tasks, so that tasks come due and
	// leave the table; the rest is noise over the full field ranges. Tasks that never
	// leave the table are capped so that it cannot clog for good.
	task automatic send_random_item();
		op_t                 op;
		kind_t               kind;
		logic [TIME_W-1:0]   now;
		logic [PERIOD_W-1:0] period;
		if ($urandom_range(99) < 12) begin
			op     = ($urandom_range(1) == 0) ? OP_CREATE : OP_TICK;
			now    = $urandom;
			kind   = kind_t'($urandom_range(3));
			period = PERIOD_W'($urandom);
		end else begin
			base_ms = base_ms + $urandom_range(15);
			now     = base_ms;
			op      = ($urandom_range(99) < 40) ? OP_CREATE : OP_TICK;
			kind    = KIND_TIMED;
			period  = PERIOD_W'($urandom_range(80));
			if ($urandom_range(99) < 15) begin
				kind = kind_t'($urandom_range(3));
				case (kind)
					KIND_PERIODIC: period = PERIOD_W'($urandom_range(60, 5));
					KIND_STRICT:   period = PERIOD_W'($urandom_range(80, 40));
					default: ;
				endcase
			end
		end
		if (op == OP_CREATE && kind != KIND_TIMED) begin
			if (lasting >= 6) begin
				kind = KIND_TIMED;
			end else begin
				lasting++;
			end
		end
		send_item(op, now, kind, period);
	endtask

	// Result side: random stalls, plus long hold-offs that fill the block and stall input.
	initial begin : receiver
		int unsigned hold_left;
		hold_left = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left == 0 && (cyc == 1500 || cyc == 12000)) begin
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= steady_window() || ($urandom_range(99) >= 25);
			end
		end
	end

	// Main stimulus and verdict.
	initial begin
		arst_n         <= 1'b0;
		item_ch.valid  <= 1'b0;
		item_ch.op     <= OP_CREATE;
		item_ch.now    <= '0;
		item_ch.kind   <= KIND_IDLE;
		item_ch.period <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, then an idle task that has not waited yet and one that has.
		send_item(OP_TICK, 32'd0, KIND_IDLE, '0);
		send_item(OP_CREATE, 32'd0, KIND_IDLE, '0);
		send_item(OP_TICK, 32'd0, KIND_IDLE, '0);
		send_item(OP_TICK, 32'd7, KIND_IDLE, '0);
		// Periodic and strict periodic tasks, a periodic pick and two equally late timed tasks.
		send_item(OP_CREATE, 32'd7, KIND_PERIODIC, 31'd3);
		send_item(OP_CREATE, 32'd7, KIND_STRICT, 31'd50);
		send_item(OP_TICK, 32'd12, KIND_IDLE, '0);
		send_item(OP_CREATE, 32'd12, KIND_TIMED, 31'd5);
		send_item(OP_CREATE, 32'd12, KIND_TIMED, 31'd5);
		send_item(OP_TICK, 32'd20, KIND_IDLE, '0);
		send_item(OP_TICK, 32'd21, KIND_IDLE, '0);
		// Fill the table, then two creates that find it full.
		send_item(OP_CREATE, 32'd21, KIND_TIMED, 31'h7FFF_FFFF);
		send_item(OP_CREATE, 32'd21, KIND_TIMED, 31'd0);
		send_item(OP_CREATE, 32'd21, KIND_TIMED, 31'd0);
		send_item(OP_CREATE, 32'd21, KIND_TIMED, 31'd0);
		send_item(OP_CREATE, 32'd21, KIND_TIMED, 31'd0);
		send_item(OP_CREATE, 32'd21, KIND_STRICT, 31'h7FFF_FFFF);
		// Largest time, a due time that wraps, and a wait that wraps through zero.
		send_item(OP_TICK, 32'hFFFF_FFFF, KIND_IDLE, '0);
		send_item(OP_CREATE, 32'hFFFF_FFFF, KIND_TIMED, 31'h7FFF_FFFF);
		send_item(OP_TICK, 32'd0, KIND_IDLE, '0);
		send_item(OP_TICK, 32'hFFFF_FFFF, KIND_IDLE, '0);
		send_item(OP_TICK, 32'h8000_0000, KIND_IDLE, '0);

		base_ms = 32'd1000;
		lasting = 3;
		repeat (1300) send_random_item();

		// Drain: wait for every expected result, then keep the clock running to catch strays.
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) begin
			@(posedge clk);
		end
		repeat (SLOTS + 8) @(posedge clk);
		if (fail_count == 0 && outstanding == 0) begin
			$display("[deadline_task_picker] OK");
		end else begin
			$display("[deadline_task_picker] ERROR");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#5_000_000;
		$display("[deadline_task_picker] ERROR");
		$finish;
	end

endmodule
